/* rtl/mmnb_pkg.sv */
// Shared types and constants for the min-max normalize block.
// Used by mmnb_sub and minmax_normalize_to_byte; no dependencies.
`timescale 1ns / 1ps

package mmnb_pkg;

    // Width of the shared subtractor: holds (diff << 8) with sign
    localparam int SUB_W = 34;
    localparam int SAMPLE_W = 24;
    localparam int PIXEL_W = 8;
    localparam int QUOT_BITS = 8;
    localparam int SENTINEL_INT = 1024;
    localparam logic [PIXEL_W-1:0] PIXEL_FULL = 8'd255;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_ACCUM = 2'd1,
        FUNC_NORM  = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RANGE,
        ST_DIFF,
        ST_CMP,
        ST_MUL,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic signed [SUB_W-1:0] diff;
        logic                    neg;
        logic                    zero;
    } sub_res_t;

endpackage

/* rtl/mmnb_sub.sv */
// Shared subtract unit: a - b with sign and zero flags.
// Depends on mmnb_pkg for widths and the result struct.
`timescale 1ns / 1ps

module mmnb_sub
    import mmnb_pkg::*;
(
    input  logic signed [SUB_W-1:0] a,
    input  logic signed [SUB_W-1:0] b,
    output sub_res_t                res
);

    logic signed [SUB_W-1:0] d;

    assign d        = a - b;
    assign res.diff = d;
    assign res.neg  = d[SUB_W-1];
    assign res.zero = (d == '0);

endmodule

/* rtl/minmax_normalize_to_byte.sv */
// Top level of the min-max normalize block: channel statistics and sequencer.
// Depends on mmnb_pkg and the shared subtractor mmnb_sub.
`timescale 1ns / 1ps

// Per-channel min-max stretch of signed fixed-point samples to 8 bits. A clear
// or accumulate transfer is absorbed in its accept cycle and the next item may
// follow at once. A normalize transfer holds item_stall high after acceptance
// through range, offset, compare, scale by 255, eight divide steps and the
// result load, ending early when the range is flat or the sample falls
// outside it, and staying high while an earlier result still waits for
// result_stall to drop; the single 34-bit subtractor performs every step in
// turn. The finished result sits in an output register, so the next item
// is taken while it waits for result_stall to drop.
module minmax_normalize_to_byte
    import mmnb_pkg::*;
#(
    parameter int MAX_CHANNELS = 4,
    parameter int FRAC_BITS    = 12
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  logic [1:0]                 func,
    input  logic [1:0]                 channel,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic [PIXEL_W-1:0]         pixel,
    output logic                       flat_range
);

    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam longint SENT_MAG = longint'(SENTINEL_INT) <<< FRAC_BITS;
    localparam logic signed [SAMPLE_W-1:0] SENT_POS =
        (SENT_MAG > longint'(SAMPLE_MAX)) ? SAMPLE_MAX : SAMPLE_W'(SENT_MAG);
    localparam logic signed [SAMPLE_W-1:0] SENT_NEG =
        (-SENT_MAG < longint'(SAMPLE_MIN)) ? SAMPLE_MIN : SAMPLE_W'(-SENT_MAG);
    localparam int RANGE_W = SAMPLE_W + 1;
    localparam int DSH_W   = RANGE_W + QUOT_BITS - 1;
    localparam int CNT_W   = $clog2(QUOT_BITS);

    state_t state_reg, state_next;

    logic signed [SAMPLE_W-1:0] chan_max_reg [MAX_CHANNELS];
    logic signed [SAMPLE_W-1:0] chan_min_reg [MAX_CHANNELS];

    logic signed [SAMPLE_W-1:0] s_reg, max_reg, min_reg;
    logic                       ok_reg;
    logic signed [RANGE_W-1:0]  range_reg, diff_reg;
    logic signed [SUB_W-1:0]    rem_reg;
    logic [DSH_W-1:0]           dsh_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [PIXEL_W-1:0]         quot_reg;
    logic [PIXEL_W-1:0]         res_pixel_reg;
    logic                       res_flat_reg;

    logic [PIXEL_W-1:0] pixel_reg;
    logic               flat_reg;
    logic               result_valid_reg;

    logic                    item_fire;
    logic                    item_ok;
    logic [CH_W-1:0]         ch_idx;
    logic                    out_free;
    logic signed [SUB_W-1:0] op_a, op_b;
    sub_res_t                sub_res;

    assign ch_idx    = channel[CH_W-1:0];
    assign item_ok   = (32'(channel) < MAX_CHANNELS);
    assign item_fire = item_valid && !item_stall;
    assign out_free  = !result_valid_reg || !result_stall;

    mmnb_sub u_sub (
        .a   (op_a),
        .b   (op_b),
        .res (sub_res)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_fire && func == FUNC_NORM)
                    state_next = ST_RANGE;
            end
            ST_RANGE:
            begin
                if (!ok_reg || sub_res.neg || sub_res.zero)
                    state_next = ST_FINISH;
                else
                    state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                if (sub_res.neg || sub_res.zero)
                    state_next = ST_FINISH;
                else
                    state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (!sub_res.neg)
                    state_next = ST_FINISH;
                else
                    state_next = ST_MUL;
            end
            ST_MUL:    state_next = ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == '0)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Operand select for the shared subtractor, and the handshake
    always_comb
    begin
        op_a       = '0;
        op_b       = '0;
        item_stall = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_RANGE:
            begin
                op_a = SUB_W'(max_reg);
                op_b = SUB_W'(min_reg);
            end
            ST_DIFF:
            begin
                op_a = SUB_W'(s_reg);
                op_b = SUB_W'(min_reg);
            end
            ST_CMP:
            begin
                op_a = SUB_W'(diff_reg);
                op_b = SUB_W'(range_reg);
            end
            ST_MUL:
            begin
                // diff * 255 as (diff << 8) - diff
                op_a = SUB_W'({diff_reg, {QUOT_BITS{1'b0}}});
                op_b = SUB_W'(diff_reg);
            end
            ST_DIV:
            begin
                op_a = rem_reg;
                op_b = SUB_W'({1'b0, dsh_reg});
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                chan_max_reg[i] <= SENT_NEG;
                chan_min_reg[i] <= SENT_POS;
            end
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (item_fire && item_ok)
            begin
                if (func == FUNC_CLEAR)
                begin
                    chan_max_reg[ch_idx] <= SENT_NEG;
                    chan_min_reg[ch_idx] <= SENT_POS;
                end
                else if (func == FUNC_ACCUM)
                begin
                    if (sample > chan_max_reg[ch_idx])
                        chan_max_reg[ch_idx] <= sample;
                    if (sample < chan_min_reg[ch_idx])
                        chan_min_reg[ch_idx] <= sample;
                end
            end
            if (state_reg == ST_FINISH && out_free)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_fire)
                begin
                    s_reg   <= sample;
                    ok_reg  <= item_ok;
                    max_reg <= chan_max_reg[ch_idx];
                    min_reg <= chan_min_reg[ch_idx];
                end
            end
            ST_RANGE:
            begin
                range_reg     <= sub_res.diff[RANGE_W-1:0];
                res_pixel_reg <= '0;
                res_flat_reg  <= !ok_reg || sub_res.neg || sub_res.zero;
            end
            ST_DIFF:
            begin
                diff_reg <= sub_res.diff[RANGE_W-1:0];
            end
            ST_CMP:
            begin
                if (!sub_res.neg)
                    res_pixel_reg <= PIXEL_FULL;
                dsh_reg <= DSH_W'({range_reg, {(QUOT_BITS-1){1'b0}}});
                cnt_reg <= CNT_W'(QUOT_BITS - 1);
            end
            ST_MUL:
            begin
                rem_reg  <= sub_res.diff;
                quot_reg <= '0;
            end
            ST_DIV:
            begin
                // Restoring step: keep the difference only when it did not go negative
                if (!sub_res.neg)
                    rem_reg <= sub_res.diff;
                quot_reg <= {quot_reg[PIXEL_W-2:0], !sub_res.neg};
                dsh_reg  <= dsh_reg >> 1;
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    res_pixel_reg <= {quot_reg[PIXEL_W-2:0], !sub_res.neg};
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    pixel_reg <= res_pixel_reg;
                    flat_reg  <= res_flat_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign result_valid = result_valid_reg;
    assign pixel        = pixel_reg;
    assign flat_range   = flat_reg;

    a_flat_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && flat_range |-> pixel == '0)
        else $error("flat range result with nonzero pixel");

    a_accum_max: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire && item_ok && func == FUNC_ACCUM
        |=> chan_max_reg[$past(ch_idx)] >= $past(sample)
            && chan_min_reg[$past(ch_idx)] <= $past(sample))
        else $error("channel statistics did not cover accumulated sample");

    a_load_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg) == ST_FINISH)
        else $error("result loaded outside the finish step");

    a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV && cnt_reg == '0 |=> state_reg == ST_FINISH)
        else $error("divider did not stop after the last quotient bit");

endmodule
